// File: rtl/csl_pkg.sv
package csl_pkg;

	// Table sizing
	localparam int MAX_POINTS   = 16;
	localparam int FRAC_BITS    = 12;
	localparam int IDX_W        = $clog2(MAX_POINTS);
	localparam int CNT_W        = $clog2(MAX_POINTS + 1);
	localparam int DEPTH        = 2 * MAX_POINTS;
	localparam int ADDR_W       = $clog2(DEPTH);
	localparam int SEARCH_STEPS = (MAX_POINTS > 2) ? $clog2(MAX_POINTS - 1) : 1;

	// Field widths
	localparam int ENTRY_W   = 4;
	localparam int KNOT_W    = 16;
	localparam int COEF_W    = 32;
	localparam int COUNT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W     = 48;
	localparam int DX_W      = KNOT_W + 1;
	localparam int PROD_W    = ACC_W + DX_W;

	// Codes
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_QUERY   = 1'b1;
	localparam logic CURVE_LARGE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_COUNT = CFG_IDX_W'(1);
	localparam logic [COUNT_W-1:0]   COUNT_RESET     = COUNT_W'(2);

	localparam logic [1:0] RANGE_INSIDE = 2'd0;
	localparam logic [1:0] RANGE_BELOW  = 2'd1;
	localparam logic [1:0] RANGE_ABOVE  = 2'd2;

	typedef struct packed {
		logic                     action;
		logic                     curve_select;
		logic [ENTRY_W-1:0]       entry_index;
		logic [KNOT_W-1:0]        knot_distance;
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
		logic signed [COEF_W-1:0] coef_d;
		logic [KNOT_W-1:0]        query_distance;
	} csl_item_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] speed;
		logic [1:0]               range_status;
	} csl_result_t;

	// Search result handed to the segment fetch
	typedef struct packed {
		csl_item_t         item;
		logic              below;
		logic              above;
		logic [IDX_W-1:0]  nm2;
		logic [IDX_W-1:0]  left;
		logic [KNOT_W-1:0] last;
	} csl_probe_t;

	// Horner work item: coef0 is consumed by the next step, the rest shift down
	typedef struct packed {
		logic [1:0]               status;
		logic signed [DX_W-1:0]   dx;
		logic signed [ACC_W-1:0]  acc;
		logic signed [COEF_W-1:0] coef0;
		logic signed [COEF_W-1:0] coef1;
		logic signed [COEF_W-1:0] coef2;
	} csl_work_t;

	function automatic logic [ADDR_W-1:0] csl_addr(input logic curve,
			input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] a;
		a = ADDR_W'(idx);
		if (curve == CURVE_LARGE) begin
			a = ADDR_W'(MAX_POINTS) + ADDR_W'(idx);
		end
		return a;
	endfunction

	function automatic logic csl_load_ok(input logic [ENTRY_W-1:0] e);
		return int'(e) < MAX_POINTS;
	endfunction

	function automatic logic [CNT_W-1:0] csl_clamp_count(input logic [COUNT_W-1:0] c);
		logic [CNT_W-1:0] n;
		if (int'(c) < 2) begin
			n = CNT_W'(2);
		end else if (int'(c) > MAX_POINTS) begin
			n = CNT_W'(MAX_POINTS);
		end else begin
			n = CNT_W'(c);
		end
		return n;
	endfunction

endpackage

// File: rtl/csl_ram.sv
module csl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/csl_search.sv
module csl_search import csl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  csl_item_t          item,
	input  logic [COUNT_W-1:0] large_count,
	input  logic [COUNT_W-1:0] small_count,
	output logic               probe_valid,
	input  logic               probe_ready,
	output csl_probe_t         probe
);

	logic              ent_adv;
	logic              ent_wr;
	logic [CNT_W-1:0]  n_in;
	logic              ent_v_s1;
	csl_item_t         ent_item_s1;
	logic [CNT_W-1:0]  ent_n_s1;
	logic [KNOT_W-1:0] knot_first;
	logic [KNOT_W-1:0] knot_last;

	logic              srch_adv    [1:SEARCH_STEPS+1];
	logic              srch_v_s    [1:SEARCH_STEPS];
	csl_item_t         srch_item_s [1:SEARCH_STEPS];
	logic              srch_below_s[1:SEARCH_STEPS];
	logic              srch_above_s[1:SEARCH_STEPS];
	logic [IDX_W-1:0]  srch_left_s [1:SEARCH_STEPS];
	logic [IDX_W-1:0]  srch_right_s[1:SEARCH_STEPS];
	logic [IDX_W-1:0]  srch_mid_s  [1:SEARCH_STEPS];
	logic [IDX_W-1:0]  srch_nm2_s  [1:SEARCH_STEPS];
	logic [KNOT_W-1:0] srch_last_s [1:SEARCH_STEPS];
	logic [KNOT_W-1:0] srch_kmid   [1:SEARCH_STEPS];
	logic [IDX_W-1:0]  upd_left    [1:SEARCH_STEPS];
	logic [IDX_W-1:0]  upd_right   [1:SEARCH_STEPS];

	// Entry stage: clamp the count, fetch first and last knot
	assign n_in = csl_clamp_count((item.curve_select == CURVE_LARGE) ? large_count : small_count);
	assign ent_adv    = !ent_v_s1 || srch_adv[1];
	assign item_stall = !ent_adv;
	assign ent_wr = item_valid && ent_adv && (item.action == ACT_LOAD) &&
		csl_load_ok(item.entry_index);

	csl_ram #(.WIDTH(KNOT_W), .DEPTH(DEPTH)) u_knot_first (
		.clk     (clk),
		.wr_en   (ent_wr),
		.wr_addr (csl_addr(item.curve_select, IDX_W'(item.entry_index))),
		.wr_data (item.knot_distance),
		.rd_en   (ent_adv),
		.rd_addr (csl_addr(item.curve_select, '0)),
		.rd_data (knot_first)
	);

	csl_ram #(.WIDTH(KNOT_W), .DEPTH(DEPTH)) u_knot_last (
		.clk     (clk),
		.wr_en   (ent_wr),
		.wr_addr (csl_addr(item.curve_select, IDX_W'(item.entry_index))),
		.wr_data (item.knot_distance),
		.rd_en   (ent_adv),
		.rd_addr (csl_addr(item.curve_select, IDX_W'(n_in - CNT_W'(1)))),
		.rd_data (knot_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_v_s1 <= 1'b0;
		end else if (ent_adv) begin
			ent_v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_adv) begin
			ent_item_s1 <= item;
			ent_n_s1    <= n_in;
		end
	end

	assign srch_adv[SEARCH_STEPS+1] = probe_ready;

	// One binary search step per stage, each with its own copy of the knots
	for (genvar j = 1; j <= SEARCH_STEPS; j++) begin : g_srch
		logic              pv;
		csl_item_t         pitem;
		logic              pbelow;
		logic              pabove;
		logic [IDX_W-1:0]  pleft;
		logic [IDX_W-1:0]  pright;
		logic [IDX_W-1:0]  pnm2;
		logic [KNOT_W-1:0] plast;
		logic [IDX_W:0]    psum;
		logic [IDX_W-1:0]  pmid;
		logic              pwr;
		logic              go_left;

		if (j == 1) begin : g_first
			always_comb begin
				pv     = ent_v_s1;
				pitem  = ent_item_s1;
				pbelow = ent_item_s1.query_distance < knot_first;
				pabove = !pbelow && (ent_item_s1.query_distance > knot_last);
				pnm2   = IDX_W'(ent_n_s1 - CNT_W'(2));
				pleft  = '0;
				pright = pnm2;
				plast  = knot_last;
			end
		end else begin : g_next
			always_comb begin
				pv     = srch_v_s[j-1];
				pitem  = srch_item_s[j-1];
				pbelow = srch_below_s[j-1];
				pabove = srch_above_s[j-1];
				pnm2   = srch_nm2_s[j-1];
				pleft  = upd_left[j-1];
				pright = upd_right[j-1];
				plast  = srch_last_s[j-1];
			end
		end

		assign psum = {1'b0, pleft} + {1'b0, pright} + (IDX_W + 1)'(1);
		assign pmid = psum[IDX_W:1];
		assign pwr  = pv && srch_adv[j] && (pitem.action == ACT_LOAD) &&
			csl_load_ok(pitem.entry_index);
		assign srch_adv[j] = !srch_v_s[j] || srch_adv[j+1];

		csl_ram #(.WIDTH(KNOT_W), .DEPTH(DEPTH)) u_knot_mid (
			.clk     (clk),
			.wr_en   (pwr),
			.wr_addr (csl_addr(pitem.curve_select, IDX_W'(pitem.entry_index))),
			.wr_data (pitem.knot_distance),
			.rd_en   (srch_adv[j]),
			.rd_addr (csl_addr(pitem.curve_select, pmid)),
			.rd_data (srch_kmid[j])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				srch_v_s[j] <= 1'b0;
			end else if (srch_adv[j]) begin
				srch_v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (srch_adv[j]) begin
				srch_item_s[j]  <= pitem;
				srch_below_s[j] <= pbelow;
				srch_above_s[j] <= pabove;
				srch_left_s[j]  <= pleft;
				srch_right_s[j] <= pright;
				srch_mid_s[j]   <= pmid;
				srch_nm2_s[j]   <= pnm2;
				srch_last_s[j]  <= plast;
			end
		end

		// Narrow the window once the knot at mid is known; hold when it has closed
		assign go_left = srch_item_s[j].query_distance < srch_kmid[j];
		assign upd_left[j] = ((srch_left_s[j] < srch_right_s[j]) && !go_left) ?
			srch_mid_s[j] : srch_left_s[j];
		assign upd_right[j] = ((srch_left_s[j] < srch_right_s[j]) && go_left) ?
			srch_mid_s[j] - IDX_W'(1) : srch_right_s[j];
	end

	assign probe_valid = srch_v_s[SEARCH_STEPS];
	assign probe = '{
		item:  srch_item_s[SEARCH_STEPS],
		below: srch_below_s[SEARCH_STEPS],
		above: srch_above_s[SEARCH_STEPS],
		nm2:   srch_nm2_s[SEARCH_STEPS],
		left:  upd_left[SEARCH_STEPS],
		last:  srch_last_s[SEARCH_STEPS]
	};

endmodule

// File: rtl/csl_segment.sv
module csl_segment import csl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       probe_valid,
	output logic       probe_ready,
	input  csl_probe_t probe,
	output logic       work_valid,
	input  logic       work_ready,
	output csl_work_t  work
);

	logic                     adv_s1;
	logic                     adv_s2;
	logic                     wr;
	logic [IDX_W-1:0]         sel;
	logic [ADDR_W-1:0]        rd_addr;
	logic [ADDR_W-1:0]        wr_addr;
	logic [KNOT_W-1:0]        knot_rd;
	logic signed [COEF_W-1:0] a_rd;
	logic signed [COEF_W-1:0] b_rd;
	logic signed [COEF_W-1:0] c_rd;
	logic signed [COEF_W-1:0] d_rd;

	logic                     seg_v_s1;
	logic                     seg_below_s1;
	logic                     seg_above_s1;
	logic [KNOT_W-1:0]        seg_dist_s1;
	logic [KNOT_W-1:0]        seg_last_s1;

	logic                     work_v_s2;
	csl_work_t                work_s2;
	csl_work_t                work_nx;
	logic [DX_W-1:0]          minuend;

	assign adv_s1      = !seg_v_s1 || adv_s2;
	assign adv_s2      = !work_v_s2 || work_ready;
	assign probe_ready = adv_s1;

	// Below range reads segment 0, above range the last segment
	assign sel = probe.below ? '0 : (probe.above ? probe.nm2 : probe.left);
	assign rd_addr = csl_addr(probe.item.curve_select, sel);
	assign wr_addr = csl_addr(probe.item.curve_select, IDX_W'(probe.item.entry_index));
	assign wr = probe_valid && adv_s1 && (probe.item.action == ACT_LOAD) &&
		csl_load_ok(probe.item.entry_index);

	csl_ram #(.WIDTH(KNOT_W), .DEPTH(DEPTH)) u_knot (
		.clk(clk), .wr_en(wr), .wr_addr(wr_addr), .wr_data(probe.item.knot_distance),
		.rd_en(adv_s1), .rd_addr(rd_addr), .rd_data(knot_rd)
	);

	csl_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_const (
		.clk(clk), .wr_en(wr), .wr_addr(wr_addr), .wr_data(probe.item.coef_a),
		.rd_en(adv_s1), .rd_addr(rd_addr), .rd_data(a_rd)
	);

	csl_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_linear (
		.clk(clk), .wr_en(wr), .wr_addr(wr_addr), .wr_data(probe.item.coef_b),
		.rd_en(adv_s1), .rd_addr(rd_addr), .rd_data(b_rd)
	);

	csl_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_square (
		.clk(clk), .wr_en(wr), .wr_addr(wr_addr), .wr_data(probe.item.coef_c),
		.rd_en(adv_s1), .rd_addr(rd_addr), .rd_data(c_rd)
	);

	csl_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_cube (
		.clk(clk), .wr_en(wr), .wr_addr(wr_addr), .wr_data(probe.item.coef_d),
		.rd_en(adv_s1), .rd_addr(rd_addr), .rd_data(d_rd)
	);

	// Loads end here: they have written their last copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_v_s1 <= 1'b0;
		end else if (adv_s1) begin
			seg_v_s1 <= probe_valid && (probe.item.action == ACT_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			seg_below_s1 <= probe.below;
			seg_above_s1 <= probe.above;
			seg_dist_s1  <= probe.item.query_distance;
			seg_last_s1  <= probe.last;
		end
	end

	// Out of range folds into the same Horner chain with zeroed terms
	always_comb begin
		minuend = seg_above_s1 ? {1'b0, seg_last_s1} : {1'b0, seg_dist_s1};
		work_nx.dx = $signed(minuend - {1'b0, knot_rd});
		if (seg_below_s1) begin
			work_nx.status = RANGE_BELOW;
		end else if (seg_above_s1) begin
			work_nx.status = RANGE_ABOVE;
		end else begin
			work_nx.status = RANGE_INSIDE;
		end
		work_nx.acc   = (seg_below_s1 || seg_above_s1) ? '0 :
			{{(ACC_W - COEF_W){d_rd[COEF_W-1]}}, d_rd};
		work_nx.coef0 = (seg_below_s1 || seg_above_s1) ? '0 : c_rd;
		work_nx.coef1 = seg_below_s1 ? '0 : b_rd;
		work_nx.coef2 = a_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_s2 <= 1'b0;
		end else if (adv_s2) begin
			work_v_s2 <= seg_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			work_s2 <= work_nx;
		end
	end

	assign work_valid = work_v_s2;
	assign work       = work_s2;

endmodule

// File: rtl/csl_step.sv
module csl_step import csl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  csl_work_t in_work,
	output logic      out_valid,
	input  logic      out_ready,
	output csl_work_t out_work
);

	localparam logic signed [PROD_W+1:0] ACC_MAX = (PROD_W + 2)'((64'sd1 <<< (ACC_W - 1)) - 1);
	localparam logic signed [PROD_W+1:0] ACC_MIN = -(PROD_W + 2)'(64'sd1 <<< (ACC_W - 1));
	localparam logic signed [PROD_W:0]   HALF    = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

	logic                     adv_s1;
	logic                     adv_s2;
	logic signed [PROD_W-1:0] prod_in;
	logic                     v_s1;
	logic signed [PROD_W-1:0] prod_s1;
	csl_work_t                work_s1;
	logic                     v_s2;
	csl_work_t                work_s2;

	logic signed [PROD_W:0]   rnd;
	logic signed [PROD_W:0]   shifted;
	logic signed [PROD_W+1:0] sum;
	logic signed [ACC_W-1:0]  acc_nx;
	csl_work_t                work_nx;

	assign adv_s1   = !v_s1 || adv_s2;
	assign adv_s2   = !v_s2 || out_ready;
	assign in_ready = adv_s1;

	assign prod_in = $signed(in_work.acc) * $signed(in_work.dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_s1 <= prod_in;
			work_s1 <= in_work;
		end
	end

	// Round half up, add the coefficient, clamp to the accumulator range
	always_comb begin
		rnd     = $signed({prod_s1[PROD_W-1], prod_s1}) + HALF;
		shifted = rnd >>> FRAC_BITS;
		sum     = $signed({shifted[PROD_W], shifted}) +
			$signed({{(PROD_W + 2 - COEF_W){work_s1.coef0[COEF_W-1]}}, work_s1.coef0});
		if (sum > ACC_MAX) begin
			acc_nx = ACC_MAX[ACC_W-1:0];
		end else if (sum < ACC_MIN) begin
			acc_nx = ACC_MIN[ACC_W-1:0];
		end else begin
			acc_nx = sum[ACC_W-1:0];
		end
		work_nx       = work_s1;
		work_nx.acc   = acc_nx;
		work_nx.coef0 = work_s1.coef1;
		work_nx.coef1 = work_s1.coef2;
		work_nx.coef2 = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			work_s2 <= work_nx;
		end
	end

	assign out_valid = v_s2;
	assign out_work  = work_s2;

endmodule

// File: rtl/cubic_spline_lookup.sv
// Cubic spline lookup over two curve tables (large and small pitch).
// Item channel (item_valid, item_stall, item): action 0 loads one knot and its
// segment coefficients a, b, c, d at entry_index of the chosen curve; action 1
// evaluates the chosen curve at query_distance. A transaction completes on a
// rising edge with item_valid high and item_stall low.
// Result channel (result_valid, result_stall, result): one transaction per
// query, none per load, in query order: speed (Q20.12, saturated) and
// range_status (0 inside, 1 below first knot, 2 above last knot).
// Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 sets the
// large curve knot count, index 1 the small one; cfg_ready is always high.
// Write it only while no query is in flight.
// Throughput: one item per cycle while no stage is stalled. On its way to the
// result an item passes the entry fetch, one stage per binary search step,
// segment fetch, dx, two stages per Horner step (multiply, then
// round/add/clamp) and the output register.
// Every stage holds its contents while the next one is full and stalled, so a
// stall on the result side backs up stage by stage to item_stall and nothing
// is lost or repeated; empty stages keep filling meanwhile.
// Reset clears the pipeline and sets both counts to 2; the tables are not
// cleared and must be loaded before they are queried.
module cubic_spline_lookup import csl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  csl_item_t            item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output csl_result_t          result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data
);

	logic [COUNT_W-1:0] large_count_q;
	logic [COUNT_W-1:0] small_count_q;

	logic       probe_valid;
	logic       probe_ready;
	csl_probe_t probe;

	// Horner chain: segment fetch feeds three steps (c, then b, then a)
	logic      w0_valid, w0_ready;
	csl_work_t w0;
	logic      w1_valid, w1_ready;
	csl_work_t w1;
	logic      w2_valid, w2_ready;
	csl_work_t w2;
	logic      w3_valid, w3_ready;
	csl_work_t w3;

	logic        res_adv;
	logic        res_valid_s1;
	csl_result_t res_s1;
	csl_result_t res_nx;
	logic        fits;

	// Config registers: drop writes to unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_count_q <= COUNT_RESET;
			small_count_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LARGE_COUNT: large_count_q <= cfg_data;
				CFG_SMALL_COUNT: small_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Find the segment: entry fetch plus one stage per search step
	csl_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.large_count (large_count_q),
		.small_count (small_count_q),
		.probe_valid (probe_valid),
		.probe_ready (probe_ready),
		.probe       (probe)
	);

	// Fetch coefficients, form dx, retire loads
	csl_segment u_segment (
		.clk         (clk),
		.arst_n      (arst_n),
		.probe_valid (probe_valid),
		.probe_ready (probe_ready),
		.probe       (probe),
		.work_valid  (w0_valid),
		.work_ready  (w0_ready),
		.work        (w0)
	);

	csl_step u_step_c (
		.clk(clk), .arst_n(arst_n),
		.in_valid(w0_valid), .in_ready(w0_ready), .in_work(w0),
		.out_valid(w1_valid), .out_ready(w1_ready), .out_work(w1)
	);

	csl_step u_step_b (
		.clk(clk), .arst_n(arst_n),
		.in_valid(w1_valid), .in_ready(w1_ready), .in_work(w1),
		.out_valid(w2_valid), .out_ready(w2_ready), .out_work(w2)
	);

	csl_step u_step_a (
		.clk(clk), .arst_n(arst_n),
		.in_valid(w2_valid), .in_ready(w2_ready), .in_work(w2),
		.out_valid(w3_valid), .out_ready(w3_ready), .out_work(w3)
	);

	// Output register: saturate the accumulator to 32 bits
	assign res_adv  = !res_valid_s1 || !result_stall;
	assign w3_ready = res_adv;

	always_comb begin
		fits = (w3.acc[ACC_W-1:COEF_W-1] == '0) || (w3.acc[ACC_W-1:COEF_W-1] == '1);
		if (fits) begin
			res_nx.speed = w3.acc[COEF_W-1:0];
		end else if (w3.acc[ACC_W-1]) begin
			res_nx.speed = {1'b1, {(COEF_W - 1){1'b0}}};
		end else begin
			res_nx.speed = {1'b0, {(COEF_W - 1){1'b1}}};
		end
		res_nx.range_status = w3.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (res_adv) begin
			res_valid_s1 <= w3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_adv) begin
			res_s1 <= res_nx;
		end
	end

	assign result_valid = res_valid_s1;
	assign result       = res_s1;

endmodule
